// ----- rtl/cfsg_pkg.sv -----
package cfsg_pkg;

    localparam int COORD_BITS   = 12;
    localparam int S_DATA_W     = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int SPAN_W       = 14;
    localparam int M_DATA_W     = ((3 * SPAN_W + 7) / 8) * 8;
    localparam int RAD_W        = 4;
    localparam int OFF_W        = 5;
    localparam int D_W          = 10;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 4'd8;
    localparam logic [D_W-1:0]   D_INIT_BASE  = 10'sd3;
    localparam logic [D_W-1:0]   D_STEP_IN    = 10'sd6;
    localparam logic [D_W-1:0]   D_STEP_OUT   = 10'sd10;

    // register index, taken from paddr[2]
    localparam logic REG_RADIUS = 1'b0;

    typedef struct packed {
        logic [SPAN_W-1:0] row;
        logic [SPAN_W-1:0] left;
        logic [SPAN_W-1:0] right;
    } span_t;

    typedef struct packed {
        logic  valid;  // span is non-empty and should be emitted
        logic  fin;    // walk finished, waiting to flush
        span_t span;
    } cand_t;

endpackage

// ----- rtl/circle_fill_span_generator_unit.sv -----
// Filled-disc span generator.
// s_ channel: one beat per disc centre (center_x, center_y). Accepted only
// while the unit is idle; s_tready stays low for the whole walk.
// m_ channel: one beat per horizontal span (row_y, span_left, span_right),
// tlast high on the final span of the disc. Spans come out in walk order.
// APB port: register 0 is the radius (1..15, 0 behaves as 1), reset 8.
// Write it only while the unit is idle.
// Timing: the Bresenham recurrence is stepped by one sequencer, one
// candidate span per cycle while the output is not stalled, up to four
// candidates per step of the recurrence. One span is held back so tlast
// can be set on the real last one. A centre of radius r takes roughly
// 0.7*r + 1 steps of the recurrence. The first span passes through the
// held-back register and then the output register before it appears.
// Reset (synchronous, aresetn low) drops any walk in progress and any
// undelivered span and reloads the radius.
// A stalled receiver freezes the walk when the output register and the
// held-back span are both full and a span must move on; nothing is dropped.
module circle_fill_span_generator_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [11:0] center_x, [23:12] center_y
    input  logic [cfsg_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [13:0] row_y, [27:14] span_left, [41:28] span_right, [47:42] zero
    output logic [cfsg_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cfsg_pkg::PADDR_W-1:0]      paddr,
    input  logic [cfsg_pkg::PDATA_W-1:0]      pwdata,
    output logic [cfsg_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import cfsg_pkg::*;

    logic [RAD_W-1:0] radius;
    cand_t            cand;
    logic             idle;
    logic             start;
    logic             advance;
    logic             out_free;

    logic             pend_vld_reg, pend_vld_next;
    span_t            pend_reg, pend_next;
    logic             out_vld_reg, out_vld_next;
    span_t            out_reg, out_next;
    logic             out_last_reg, out_last_next;

    cfsg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .radius  (radius)
    );

    assign s_tready = idle;
    assign start    = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    // hold the walk only when a span must move out and the output is full
    assign advance = out_free || !(cand.fin || (cand.valid && pend_vld_reg));

    cfsg_walker u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .radius   (radius),
        .center_x (s_tdata[COORD_BITS-1:0]),
        .center_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .advance  (advance),
        .cand     (cand),
        .idle     (idle)
    );

    always_comb begin
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end
        if (advance) begin
            if (cand.valid) begin
                if (pend_vld_reg) begin
                    out_vld_next  = 1'b1;
                    out_next      = pend_reg;
                    out_last_next = 1'b0;
                end
                pend_vld_next = 1'b1;
                pend_next     = cand.span;
            end else if (cand.fin && pend_vld_reg) begin
                out_vld_next  = 1'b1;
                out_next      = pend_reg;
                out_last_next = 1'b1;
                pend_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W-3*SPAN_W){1'b0}},
                       out_reg.right, out_reg.left, out_reg.row};

endmodule

// ----- rtl/cfsg_regs.sv -----
module cfsg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfsg_pkg::PADDR_W-1:0] paddr,
    input  logic [cfsg_pkg::PDATA_W-1:0] pwdata,
    output logic [cfsg_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [cfsg_pkg::RAD_W-1:0]   radius
);
    import cfsg_pkg::*;

    logic [RAD_W-1:0] radius_reg;
    logic [RAD_W-1:0] radius_next;

    assign pready = 1'b1;

    always_comb begin
        radius_next = radius_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIUS)) begin
            radius_next = pwdata[RAD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else begin
            radius_reg <= radius_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_RADIUS) begin
            prdata = {{(PDATA_W-RAD_W){1'b0}}, radius_reg};
        end
    end

    assign radius = radius_reg;

endmodule

// ----- rtl/cfsg_walker.sv -----
module cfsg_walker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [cfsg_pkg::RAD_W-1:0]      radius,
    input  logic [cfsg_pkg::COORD_BITS-1:0] center_x,
    input  logic [cfsg_pkg::COORD_BITS-1:0] center_y,
    input  logic                           advance,
    output cfsg_pkg::cand_t                cand,
    output logic                           idle
);
    import cfsg_pkg::*;

    typedef enum logic [5:0] {
        W_IDLE = 6'b000001,
        W_Y0   = 6'b000010,
        W_Y1   = 6'b000100,
        W_X0   = 6'b001000,
        W_X1   = 6'b010000,
        W_FIN  = 6'b100000
    } wstate_t;

    wstate_t                state_reg, state_next;
    logic [OFF_W-1:0]       x_reg, x_next;
    logic [OFF_W-1:0]       y_reg, y_next;
    logic signed [D_W-1:0]  d_reg, d_next;
    logic [COORD_BITS-1:0]  cx_reg, cx_next;
    logic [COORD_BITS-1:0]  cy_reg, cy_next;

    logic [OFF_W-1:0]       r_eff;
    logic                   y_phase, x_phase, minus;
    logic [OFF_W-1:0]       half, off;
    logic [SPAN_W-1:0]      cx_s, cy_s, half_s, off_s;
    logic signed [D_W-1:0]  x4, y4, d_upd;
    logic                   y_dec;
    logic [OFF_W-1:0]       x_inc, y_upd;
    wstate_t                after_step;

    assign r_eff   = (radius == '0) ? OFF_W'(1) : OFF_W'(radius);
    assign y_phase = (state_reg == W_Y0) || (state_reg == W_Y1);
    assign x_phase = (state_reg == W_X0) || (state_reg == W_X1);
    assign minus   = (state_reg == W_Y1) || (state_reg == W_X1);
    // row offset and half width swap roles between the two phases
    assign half    = y_phase ? x_reg : y_reg;
    assign off     = y_phase ? y_reg : x_reg;

    assign cx_s   = SPAN_W'(cx_reg);
    assign cy_s   = SPAN_W'(cy_reg);
    assign half_s = SPAN_W'(half);
    assign off_s  = SPAN_W'(off);

    always_comb begin
        cand            = '0;
        cand.valid      = (y_phase || x_phase) && (half != '0);
        cand.fin        = (state_reg == W_FIN);
        cand.span.row   = minus ? (cy_s - off_s) : (cy_s + off_s);
        cand.span.left  = cx_s - half_s + SPAN_W'(1);
        cand.span.right = cx_s + half_s - SPAN_W'(1);
    end

    // one step of the decision recurrence
    assign x4    = D_W'({x_reg, 2'b00});
    assign y4    = D_W'({y_reg, 2'b00});
    assign y_dec = ~d_reg[D_W-1];
    assign d_upd = y_dec ? (d_reg + x4 - y4 + D_STEP_OUT) : (d_reg + x4 + D_STEP_IN);
    assign x_inc = x_reg + OFF_W'(1);
    assign y_upd = y_dec ? (y_reg - OFF_W'(1)) : y_reg;

    always_comb begin
        if (x_inc <= y_upd) begin
            after_step = y_dec ? W_Y0 : W_X0;
        end else begin
            after_step = W_FIN;
        end
    end

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        d_next     = d_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        case (state_reg)
            W_IDLE: begin
                if (start) begin
                    cx_next    = center_x;
                    cy_next    = center_y;
                    x_next     = '0;
                    y_next     = r_eff;
                    d_next     = D_INIT_BASE - D_W'({r_eff, 1'b0});
                    state_next = W_Y0;
                end
            end
            W_Y0: begin
                if (advance) begin
                    state_next = (y_reg != '0) ? W_Y1 : W_X0;
                end
            end
            W_Y1: begin
                if (advance) begin
                    state_next = W_X0;
                end
            end
            W_X0: begin
                if (advance) begin
                    if (x_reg != '0) begin
                        state_next = W_X1;
                    end else begin
                        x_next     = x_inc;
                        y_next     = y_upd;
                        d_next     = d_upd;
                        state_next = after_step;
                    end
                end
            end
            W_X1: begin
                if (advance) begin
                    x_next     = x_inc;
                    y_next     = y_upd;
                    d_next     = d_upd;
                    state_next = after_step;
                end
            end
            W_FIN: begin
                if (advance) begin
                    state_next = W_IDLE;
                end
            end
            default: begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg  <= x_next;
        y_reg  <= y_next;
        d_reg  <= d_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
    end

    assign idle = (state_reg == W_IDLE);

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
    import cfsg_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int STALL_MAX      = 19;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_SPANS      = 48;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_ITEMS    = 30;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [PADDR_W-1:0] RADIUS_ADDR = {REG_RADIUS, 2'b00};

    typedef struct packed {
        logic [SPAN_W-1:0] row;
        logic [SPAN_W-1:0] left;
        logic [SPAN_W-1:0] right;
        logic              is_last;
    } span_beat_t;

    class disc_span_scoreboard;
        span_beat_t expected_spans[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_LIMIT) $display("%s", msg);
        endfunction

        function void add_span(int base, int row, int left, int right);
            span_beat_t b;
            if (left > right || expected_spans.size() - base >= MAX_SPANS) return;
            b.row     = row[SPAN_W-1:0];
            b.left    = left[SPAN_W-1:0];
            b.right   = right[SPAN_W-1:0];
            b.is_last = 1'b0;
            expected_spans.push_back(b);
        endfunction

        // Bresenham walk over one disc, spans in walk order
        function void note_centre(int cx, int cy, int rad);
            int r = (rad == 0) ? 1 : rad;
            int x = 0;
            int y = r;
            int d = 3 - 2 * r;
            int prev_x = -1;
            int prev_y = -1;
            int base = expected_spans.size();
            while (x <= y) begin
                if (prev_y != y) begin
                    prev_y = y;
                    add_span(base, cy + y, cx - x + 1, cx + x - 1);
                    if (y != 0) add_span(base, cy - y, cx - x + 1, cx + x - 1);
                end
                if (prev_x != x) begin
                    prev_x = x;
                    add_span(base, cy + x, cx - y + 1, cx + y - 1);
                    if (x != 0) add_span(base, cy - x, cx - y + 1, cx + y - 1);
                end
                if (d < 0) begin
                    d = d + 4 * x + 6;
                end else begin
                    d = d + 4 * (x - y) + 10;
                    y = y - 1;
                end
                x = x + 1;
            end
            if (expected_spans.size() > base) expected_spans[$].is_last = 1'b1;
        endfunction

        function void check_span(logic [M_DATA_W-1:0] data, logic tlast);
            span_beat_t got;
            span_beat_t want;
            got.row     = data[SPAN_W-1:0];
            got.left    = data[2*SPAN_W-1:SPAN_W];
            got.right   = data[3*SPAN_W-1:2*SPAN_W];
            got.is_last = tlast;
            if (expected_spans.size() == 0) begin
                report($sformatf("unexpected span: row %0d cols %0d..%0d last %0b",
                    $signed(got.row), $signed(got.left), $signed(got.right), got.is_last));
                return;
            end
            want = expected_spans.pop_front();
            if (got !== want)
                report($sformatf({"span mismatch: expected row %0d cols %0d..%0d last %0b,",
                    " got row %0d cols %0d..%0d last %0b"},
                    $signed(want.row), $signed(want.left), $signed(want.right), want.is_last,
                    $signed(got.row), $signed(got.left), $signed(got.right), got.is_last));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // [11:0] center_x, [23:12] center_y
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // [13:0] row_y, [27:14] span_left, [41:28] span_right
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    disc_span_scoreboard   sb;
    logic [RAD_W-1:0]      radius_shadow;
    int                    src_quiet;
    int                    sink_quiet;
    int                    idle_cycles;

    circle_fill_span_generator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // per-beat idle count, with occasional runs of back-to-back beats
    function automatic int next_gap(ref int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            quiet = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, STALL_MAX);
    endfunction

    function automatic logic [COORD_BITS-1:0] random_coord();
        case ($urandom_range(0, 7))
            0: return COORD_BITS'($urandom_range(0, 20));
            1: return COORD_BITS'($urandom_range(4075, 4095));
            default: return COORD_BITS'($urandom());
        endcase
    endfunction

    task automatic send_centre(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy);
        int gap;
        gap = next_gap(src_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({cy, cx});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_centre(cx, cy, radius_shadow);
    endtask

    // let every span of the current discs out, then give the unit time to go idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_spans.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_radius(input logic [RAD_W-1:0] value);
        logic [PDATA_W-1:0] wd;
        logic [PDATA_W-1:0] rd;
        wd = $urandom();
        wd[RAD_W-1:0] = value;
        apb_access(1'b1, RADIUS_ADDR, wd, rd);
        radius_shadow = value;
        @(posedge aclk);
        apb_access(1'b0, RADIUS_ADDR, '0, rd);
        if (rd[RAD_W-1:0] !== value)
            sb.report($sformatf("radius read-back: expected %0d, got %0d", value, rd[RAD_W-1:0]));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_span(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        int stall;
        sink_quiet = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = next_gap(sink_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int rad;
        sb            = new();
        radius_shadow = RADIUS_RESET;
        src_quiet     = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset radius, corners push rows and columns off canvas
        send_centre(12'd0, 12'd0);
        send_centre(12'd4095, 12'd4095);
        send_centre(12'd0, 12'd4095);
        send_centre(12'd4095, 12'd0);
        send_centre(12'd2048, 12'd1000);
        drain();

        // smallest disc: one single-pixel span on the centre row, empty rows above and below get skipped
        set_radius(4'd1);
        send_centre(12'd0, 12'd0);
        send_centre(12'd4095, 12'd4095);
        send_centre(12'd100, 12'd200);
        drain();

        // largest disc, most spans per centre
        set_radius(4'd15);
        send_centre(12'd0, 12'd0);
        send_centre(12'd4095, 12'd4095);
        send_centre(12'd0, 12'd4095);
        send_centre(12'd4095, 12'd0);
        drain();

        // zero behaves as one
        set_radius(4'd0);
        send_centre(12'd0, 12'd0);
        send_centre(12'd4095, 12'd4095);
        send_centre(12'd1234, 12'd3210);
        drain();

        set_radius(4'd2);
        send_centre(12'd5, 12'd5);
        send_centre(12'd4090, 12'd7);
        drain();

        set_radius(4'd3);
        send_centre(12'hAAA, 12'h555);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) rad = 15;
            else if (p == 1) rad = 1;
            else if (p == 2) rad = 0;
            else rad = $urandom_range(0, 15);
            set_radius(RAD_W'(rad));
            for (int i = 0; i < PHASE_ITEMS; i++) send_centre(random_coord(), random_coord());
            drain();
        end

        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
